// ===== sv/digital_input_on_off_delay_defines.svh =====
// Assertion macros for the on/off delay block.
`ifndef DIGITAL_INPUT_ON_OFF_DELAY_DEFINES_SVH
`define DIGITAL_INPUT_ON_OFF_DELAY_DEFINES_SVH

// Same-cycle implication.
`define DOD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DOD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dod_pkg.sv =====
`default_nettype none

package dod_pkg;

    localparam int BIT_LIMIT = 32;
    localparam int WORD_W    = 32;
    localparam int COUNT_W   = 6;
    localparam int BIT_IW    = 5;
    localparam int CFG_AW    = 3;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_AW-1:0] REG_LOW_WAIT  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_HIGH_WAIT = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FADE      = 3'd2;
    localparam logic [CFG_AW-1:0] REG_INIT_BITS = 3'd3;
    localparam logic [CFG_AW-1:0] REG_ACTIVE    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_WALK,
        ST_OUT
    } state_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_UPDATE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic low_pend;
        logic high_pend;
        logic last_in;
        logic out_lvl;
    } chan_state_t;

endpackage

`default_nettype wire

// ===== sv/dod_start_ram.sv =====
`default_nettype none

module dod_start_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int DW    = 32
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [DW-1:0] wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/dod_timer_unit.sv =====
`default_nettype none

// Shared per-channel timer unit: ages registered, then wait/fade decision.
module dod_timer_unit #(
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       load,
    input  wire logic [TIME_WIDTH-1:0]      now,
    input  wire logic [TIME_WIDTH-1:0]      low_start,
    input  wire logic [TIME_WIDTH-1:0]      high_start,
    input  wire logic [dod_pkg::WORD_W-1:0] low_wait,
    input  wire logic [dod_pkg::WORD_W-1:0] high_wait,
    input  wire logic [dod_pkg::WORD_W-1:0] fade,
    input  wire dod_pkg::chan_state_t       cur,
    output dod_pkg::chan_state_t            nxt
);

    localparam int CW = (TIME_WIDTH > dod_pkg::WORD_W) ? TIME_WIDTH : dod_pkg::WORD_W;

    logic [TIME_WIDTH-1:0] age_low_reg;
    logic [TIME_WIDTH-1:0] age_high_reg;
    logic [CW-1:0]         a0;
    logic [CW-1:0]         a1;
    logic                  a1_lt_a0;
    logic                  a0_lt_a1;
    logic                  a1_ge_fade;
    logic                  a0_ge_fade;
    logic                  a0_ge_low;
    logic                  a1_ge_high;
    dod_pkg::chan_state_t  mid;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            age_low_reg  <= now - low_start;
            age_high_reg <= now - high_start;
        end
    end

    assign a0         = CW'(age_low_reg);
    assign a1         = CW'(age_high_reg);
    assign a1_lt_a0   = a1 < a0;
    assign a0_lt_a1   = a0 < a1;
    assign a1_ge_fade = a1 >= CW'(fade);
    assign a0_ge_fade = a0 >= CW'(fade);
    assign a0_ge_low  = a0 >= CW'(low_wait);
    assign a1_ge_high = a1 >= CW'(high_wait);

    // low wait first, high wait sees its outcome
    always_comb
    begin
        mid = cur;
        if (cur.low_pend)
        begin
            if (cur.high_pend && a1_lt_a0 && a1_ge_fade)
            begin
                mid.low_pend = 1'b0;
            end
            else if (a0_ge_low)
            begin
                mid.low_pend = 1'b0;
                if (!cur.last_in && cur.out_lvl)
                begin
                    mid.out_lvl   = 1'b0;
                    mid.high_pend = 1'b0;
                end
            end
        end
        nxt = mid;
        if (mid.high_pend)
        begin
            if (mid.low_pend && a0_lt_a1 && a0_ge_fade)
            begin
                nxt.high_pend = 1'b0;
            end
            else if (a1_ge_high)
            begin
                nxt.high_pend = 1'b0;
                if (mid.last_in && !mid.out_lvl)
                begin
                    nxt.out_lvl  = 1'b1;
                    nxt.low_pend = 1'b0;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/digital_input_on_off_delay.sv =====
// Multichannel on/off delay. A tick transaction (tuser = 0) advances the time
// counter, walks the active channels one per cycle through the start-time RAMs
// and the shared timer unit, and returns one result with the delayed output
// bits; the walk rate is set by the single read port of the start-time RAMs,
// and a tick passes through accept, the channel walk, two pipeline drain
// stages, a turnaround and the output state.
// An update transaction (tuser = 1) records levels and arms idle timers one
// channel per cycle over the clamped bit count of channels, with no result. The
// block takes no new transaction while a tick or update is in progress; a
// finished result waits in the output register while updates keep being
// accepted.
`default_nettype none
`include "digital_input_on_off_delay_defines.svh"

module digital_input_on_off_delay #(
    parameter int CHANNELS   = 32,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [31:0] new_bits, [37:32] bit_count, [39:38] zero
    input  wire logic [dod_pkg::IN_DATA_W-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                           s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] output_bits, [37:32] channel_count, [39:38] zero
    output logic      [dod_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                           cfg_we,
    input  wire logic [dod_pkg::CFG_AW-1:0]     cfg_addr,
    input  wire logic [dod_pkg::WORD_W-1:0]     cfg_data
);

    localparam int NCH    = (CHANNELS < dod_pkg::BIT_LIMIT) ? CHANNELS : dod_pkg::BIT_LIMIT;
    localparam int CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int CNT_W  = $clog2(NCH + 1);
    localparam int BIT_IW = dod_pkg::BIT_IW;
    localparam int CNT6   = dod_pkg::COUNT_W;
    localparam int WW     = dod_pkg::WORD_W;

    dod_pkg::state_t       state_reg, state_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [WW-1:0]         last_reg, last_next;
    logic [WW-1:0]         out_reg, out_next;
    logic [NCH-1:0]        lp_reg, lp_next;
    logic [NCH-1:0]        hp_reg, hp_next;
    logic [WW-1:0]         low_wait_reg, low_wait_next;
    logic [WW-1:0]         high_wait_reg, high_wait_next;
    logic [WW-1:0]         fade_reg, fade_next;
    logic [CNT6-1:0]       act_reg, act_next;
    logic [CNT_W-1:0]      ch_reg, ch_next;
    logic [WW-1:0]         upd_bits_reg, upd_bits_next;
    logic [CNT_W-1:0]      upd_cnt_reg, upd_cnt_next;
    logic                  p1_v_reg, p1_v_next;
    logic                  p2_v_reg;
    logic [CH_W-1:0]       p1_ch_reg;
    logic [CH_W-1:0]       p2_ch_reg;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [WW-1:0]         obits_reg, obits_next;
    logic [CNT6-1:0]       ocnt_reg, ocnt_next;

    logic [CNT6-1:0]       eff;
    logic [CNT6-1:0]       in_cnt;
    logic [CNT6-1:0]       clamp;
    logic [WW-1:0]         in_bits;
    logic [WW-1:0]         upd_mask;
    logic [CH_W-1:0]       ch_idx;
    logic [BIT_IW-1:0]     ch_bit;
    logic [BIT_IW-1:0]     p2_bit;
    logic                  low_we;
    logic                  high_we;
    logic [TIME_WIDTH-1:0] low_start;
    logic [TIME_WIDTH-1:0] high_start;
    dod_pkg::chan_state_t  cur_st;
    dod_pkg::chan_state_t  dec_st;

    assign in_bits = s_tdata[31:0];
    assign in_cnt  = s_tdata[37:32];
    assign ch_idx  = ch_reg[CH_W-1:0];
    assign ch_bit  = BIT_IW'(ch_idx);
    assign p2_bit  = BIT_IW'(p2_ch_reg);

    always_comb
    begin
        eff = (act_reg == '0) ? CNT6'(1) : act_reg;
        if (eff > CNT6'(NCH))
        begin
            eff = CNT6'(NCH);
        end
    end

    assign clamp = (in_cnt > eff) ? eff : in_cnt;

    always_comb
    begin
        for (int i = 0; i < WW; i++)
        begin
            upd_mask[i] = CNT6'(i) < clamp;
        end
    end

    dod_start_ram #(
        .DEPTH (NCH),
        .AW    (CH_W),
        .DW    (TIME_WIDTH)
    ) u_low_ram (
        .clk   (clk),
        .we    (low_we),
        .waddr (ch_idx),
        .wdata (now_reg),
        .raddr (ch_idx),
        .rdata (low_start)
    );

    dod_start_ram #(
        .DEPTH (NCH),
        .AW    (CH_W),
        .DW    (TIME_WIDTH)
    ) u_high_ram (
        .clk   (clk),
        .we    (high_we),
        .waddr (ch_idx),
        .wdata (now_reg),
        .raddr (ch_idx),
        .rdata (high_start)
    );

    assign cur_st.low_pend  = lp_reg[p2_ch_reg];
    assign cur_st.high_pend = hp_reg[p2_ch_reg];
    assign cur_st.last_in   = last_reg[p2_bit];
    assign cur_st.out_lvl   = out_reg[p2_bit];

    dod_timer_unit #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_timer (
        .clk        (clk),
        .load       (p1_v_reg),
        .now        (now_reg),
        .low_start  (low_start),
        .high_start (high_start),
        .low_wait   (low_wait_reg),
        .high_wait  (high_wait_reg),
        .fade       (fade_reg),
        .cur        (cur_st),
        .nxt        (dec_st)
    );

    always_comb
    begin
        state_next     = state_reg;
        now_next       = now_reg;
        last_next      = last_reg;
        out_next       = out_reg;
        lp_next        = lp_reg;
        hp_next        = hp_reg;
        low_wait_next  = low_wait_reg;
        high_wait_next = high_wait_reg;
        fade_next      = fade_reg;
        act_next       = act_reg;
        ch_next        = ch_reg;
        upd_bits_next  = upd_bits_reg;
        upd_cnt_next   = upd_cnt_reg;
        p1_v_next      = 1'b0;
        m_tvalid_next  = m_tvalid_reg;
        obits_next     = obits_reg;
        ocnt_next      = ocnt_reg;
        low_we         = 1'b0;
        high_we        = 1'b0;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            dod_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (dod_pkg::opcode_t'(s_tuser) == dod_pkg::OP_TICK)
                    begin
                        now_next   = now_reg + 1'b1;
                        ch_next    = '0;
                        state_next = dod_pkg::ST_WALK;
                    end
                    else if (clamp != '0)
                    begin
                        last_next     = (last_reg & ~upd_mask) | (in_bits & upd_mask);
                        upd_bits_next = in_bits;
                        upd_cnt_next  = CNT_W'(clamp);
                        ch_next       = '0;
                        state_next    = dod_pkg::ST_UPD;
                    end
                end
            end
            dod_pkg::ST_UPD:
            begin
                if (upd_bits_reg[ch_bit])
                begin
                    if (!hp_reg[ch_idx])
                    begin
                        hp_next[ch_idx] = 1'b1;
                        high_we         = 1'b1;
                    end
                end
                else if (!lp_reg[ch_idx])
                begin
                    lp_next[ch_idx] = 1'b1;
                    low_we          = 1'b1;
                end
                ch_next = ch_reg + 1'b1;
                if (ch_next == upd_cnt_reg)
                begin
                    state_next = dod_pkg::ST_IDLE;
                end
            end
            dod_pkg::ST_WALK:
            begin
                p1_v_next = CNT6'(ch_reg) < eff;
                if (p1_v_next)
                begin
                    ch_next = ch_reg + 1'b1;
                end
                if (p2_v_reg)
                begin
                    lp_next[p2_ch_reg] = dec_st.low_pend;
                    hp_next[p2_ch_reg] = dec_st.high_pend;
                    out_next[p2_bit]   = dec_st.out_lvl;
                end
                if (!p1_v_next && !p1_v_reg && !p2_v_reg)
                begin
                    state_next = dod_pkg::ST_OUT;
                end
            end
            dod_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    obits_next    = out_reg;
                    ocnt_next     = eff;
                    state_next    = dod_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dod_pkg::ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            unique case (cfg_addr)
                dod_pkg::REG_LOW_WAIT:  low_wait_next  = cfg_data;
                dod_pkg::REG_HIGH_WAIT: high_wait_next = cfg_data;
                dod_pkg::REG_FADE:      fade_next      = cfg_data;
                dod_pkg::REG_INIT_BITS:
                begin
                    last_next = cfg_data;
                    out_next  = cfg_data;
                end
                dod_pkg::REG_ACTIVE:    act_next       = cfg_data[CNT6-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dod_pkg::ST_IDLE;
            now_reg       <= '0;
            last_reg      <= '0;
            out_reg       <= '0;
            lp_reg        <= '0;
            hp_reg        <= '0;
            low_wait_reg  <= '0;
            high_wait_reg <= '0;
            fade_reg      <= '0;
            act_reg       <= CNT6'(dod_pkg::BIT_LIMIT);
            ch_reg        <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            now_reg       <= now_next;
            last_reg      <= last_next;
            out_reg       <= out_next;
            lp_reg        <= lp_next;
            hp_reg        <= hp_next;
            low_wait_reg  <= low_wait_next;
            high_wait_reg <= high_wait_next;
            fade_reg      <= fade_next;
            act_reg       <= act_next;
            ch_reg        <= ch_next;
            p1_v_reg      <= p1_v_next;
            p2_v_reg      <= p1_v_reg;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        upd_bits_reg <= upd_bits_next;
        upd_cnt_reg  <= upd_cnt_next;
        p1_ch_reg    <= ch_idx;
        p2_ch_reg    <= p1_ch_reg;
        obits_reg    <= obits_next;
        ocnt_reg     <= ocnt_next;
    end

    assign s_tready = (state_reg == dod_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, ocnt_reg, obits_reg};

    `DOD_ASSERT_NEXT(a_now_step, s_tvalid && s_tready && !s_tuser,
        now_reg == $past(now_reg) + 1'b1, "time counter did not advance on tick")
    `DOD_ASSERT_NEXT(a_now_hold, !(s_tvalid && s_tready && !s_tuser),
        $stable(now_reg), "time counter moved without tick")
    `DOD_ASSERT_NOW(a_ready_drained, s_tready,
        !p1_v_reg && !p2_v_reg && !low_we && !high_we, "ready while channel walk busy")

endmodule

`default_nettype wire
